### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each check is sampled on the rising
// clock edge and is disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// A condition that holds at every clock edge.
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rstn, cond)
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### hw/rtl/sbmc_pkg.sv
package sbmc_pkg;

    // Width of the phase sequencer step code.
    localparam int STEP_W = 7;

    // Fixed step codes; those after the reset pulses depend on the pulse count.
    localparam logic [STEP_W-1:0] PS_IDLE = 7'd127;
    localparam logic [STEP_W-1:0] PS_CLK  = 7'd2;

    // Length of one byte read, in phases.
    localparam int RD_LEN = 21;

    // Sensor commands and bit mask for MSB-first shifting.
    localparam logic [7:0] CMD_TEMP = 8'h03;
    localparam logic [7:0] CMD_HUMI = 8'h05;
    localparam logic [7:0] BIT_TOP  = 8'h80;

    // Transmission-start pattern, bit i is phase i of the pattern.
    localparam logic [7:0] TS_SDA = 8'b1100_0111;
    localparam logic [7:0] TS_SCL = 8'b0110_1100;

    // Reset value of the timeout register.
    localparam logic [19:0] TIMEOUT_RESET = 20'd400000;

    // Completion status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOACK   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    typedef struct packed {
        logic func;
        logic mode;
        logic sda_in;
    } sbmc_in_t;

    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        sda_oe;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] reading;
        logic [7:0]  checksum;
    } sbmc_out_t;

    // Quotient by three for values up to 23, by reciprocal multiplication.
    function automatic logic [2:0] div3(input logic [4:0] v);
        logic [9:0] prod;
        prod = {5'b0, v} * 10'd11;
        return prod[7:5];
    endfunction

endpackage

### hw/rtl/sbmc_seq.sv
`include "assert_macros.svh"

module sbmc_seq #(
    parameter int RESET_CLOCKS = 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  sbmc_pkg::sbmc_in_t item,
    input  logic [19:0]        timeout_limit,
    output sbmc_pkg::sbmc_out_t result
);
    import sbmc_pkg::*;

    // Step codes that follow from the number of reset pulses.
    localparam logic [STEP_W-1:0] PS_TS     = STEP_W'(2 + 2 * RESET_CLOCKS);
    localparam logic [STEP_W-1:0] PS_WR     = STEP_W'(2 + 2 * RESET_CLOCKS + 8);
    localparam logic [STEP_W-1:0] PS_REL    = STEP_W'(2 + 2 * RESET_CLOCKS + 32);
    localparam logic [STEP_W-1:0] PS_ACK    = STEP_W'(2 + 2 * RESET_CLOCKS + 33);
    localparam logic [STEP_W-1:0] PS_POLL   = STEP_W'(2 + 2 * RESET_CLOCKS + 34);
    localparam logic [STEP_W-1:0] PS_RD     = STEP_W'(2 + 2 * RESET_CLOCKS + 35);
    localparam logic [STEP_W-1:0] PS_RD_END = STEP_W'(2 + 2 * RESET_CLOCKS + 35 + RD_LEN);

    logic [STEP_W-1:0] phase_reg, phase_next;
    logic [1:0]        byte_reg, byte_next;
    logic [7:0]        shift_reg, shift_next;
    logic [19:0]       poll_reg, poll_next;
    logic              mode_reg, mode_next;
    logic [15:0]       value_reg, value_next;
    logic [7:0]        check_reg, check_next;

    logic              start;
    logic [STEP_W-1:0] p;
    logic [19:0]       poll_inc;
    logic [2:0]        ts_off;
    logic [4:0]        wr_off;
    logic [2:0]        wr_bit;
    logic [4:0]        wr_rem;
    logic [7:0]        cmd;
    logic [4:0]        rd_off;
    logic [3:0]        rd_k;

    // One bus phase: a start request in idle begins the sequence in this phase.
    always_comb begin
        start      = (phase_reg == PS_IDLE) && item.func;
        p          = start ? '0 : phase_reg;
        mode_next  = start ? item.mode : mode_reg;
        value_next = start ? '0 : value_reg;
        check_next = start ? '0 : check_reg;
        poll_next  = start ? '0 : poll_reg;
        byte_next  = start ? '0 : byte_reg;
        shift_next = start ? '0 : shift_reg;
        phase_next = STEP_W'(p + 1'b1);

        poll_inc = poll_next + 20'd1;
        ts_off   = 3'(p - PS_TS);
        wr_off   = 5'(p - PS_WR);
        wr_bit   = div3(wr_off);
        wr_rem   = wr_off - ({1'b0, wr_bit, 1'b0} + {2'b0, wr_bit});
        cmd      = mode_next ? CMD_HUMI : CMD_TEMP;
        rd_off   = 5'(p - PS_RD);
        rd_k     = 4'(rd_off - 5'd1);

        result.scl      = 1'b0;
        result.sda_out  = 1'b1;
        result.sda_oe   = 1'b0;
        result.busy_res = 1'b1;
        result.done_res = 1'b0;
        result.status   = ST_OK;

        if (p == PS_IDLE) begin
            result.busy_res = 1'b0;
            phase_next      = PS_IDLE;
        end else if (p < PS_CLK) begin
            result.sda_oe = 1'b1;
        end else if (p < PS_TS) begin
            // Connection reset: clock pulses with data held high.
            result.sda_oe = 1'b1;
            result.scl    = ~p[0];
        end else if (p < PS_WR) begin
            result.sda_oe  = 1'b1;
            result.sda_out = TS_SDA[ts_off];
            result.scl     = TS_SCL[ts_off];
        end else if (p < PS_REL) begin
            // Command byte, three phases per bit with the clock high in the middle.
            result.sda_oe  = 1'b1;
            result.sda_out = cmd[3'd7 - wr_bit];
            result.scl     = (wr_rem == 5'd1);
        end else if (p == PS_REL) begin
            result.sda_oe = 1'b0;
        end else if (p == PS_ACK) begin
            result.scl = 1'b1;
            if (item.sda_in) begin
                result.busy_res = 1'b0;
                result.done_res = 1'b1;
                result.status   = ST_NOACK;
                phase_next      = PS_IDLE;
            end
        end else if (p == PS_POLL) begin
            // Wait for the sensor to pull data low, counting high samples.
            if (!item.sda_in) begin
                phase_next = PS_RD;
            end else begin
                poll_next = poll_inc;
                if (poll_inc >= timeout_limit || poll_inc == '0) begin
                    result.busy_res = 1'b0;
                    result.done_res = 1'b1;
                    result.status   = ST_TIMEOUT;
                    phase_next      = PS_IDLE;
                end else begin
                    phase_next = PS_POLL;
                end
            end
        end else if (p >= PS_RD && p < PS_RD_END) begin
            if (rd_off == 5'd0) begin
                shift_next = '0;
            end else if (rd_off <= 5'd16) begin
                // Sample on the clock-high phase of each bit.
                if (!rd_k[0]) begin
                    result.scl = 1'b1;
                    if (item.sda_in) begin
                        shift_next = shift_next | (BIT_TOP >> rd_k[3:1]);
                    end
                end
            end else begin
                // Acknowledge slot: low for the first two bytes, high for the last.
                result.sda_oe = 1'b1;
                if (rd_off == 5'd17) begin
                    if (byte_next == 2'd0) begin
                        value_next = {shift_next, 8'h00};
                    end else if (byte_next == 2'd1) begin
                        value_next = {value_next[15:8], shift_next};
                    end else begin
                        check_next = shift_next;
                    end
                end
                result.sda_out = (rd_off == 5'd20) || byte_next[1];
                result.scl     = (rd_off == 5'd18);
                if (rd_off == 5'd20) begin
                    if (byte_next[1]) begin
                        result.busy_res = 1'b0;
                        result.done_res = 1'b1;
                        result.status   = ST_OK;
                        phase_next      = PS_IDLE;
                    end else begin
                        byte_next  = byte_next + 2'd1;
                        phase_next = PS_RD;
                    end
                end
            end
        end else begin
            // A step code that names no phase falls back to idle.
            result.busy_res = 1'b0;
            phase_next      = PS_IDLE;
        end

        result.reading  = value_next;
        result.checksum = check_next;
    end

    // Sequencer state advances once per transfer handed on to the output stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PS_IDLE;
            byte_reg  <= '0;
            shift_reg <= '0;
            poll_reg  <= '0;
            mode_reg  <= 1'b0;
            value_reg <= '0;
            check_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            poll_reg  <= poll_next;
            mode_reg  <= mode_next;
            value_reg <= value_next;
            check_reg <= check_next;
        end
    end

    `ASSERT_NEXT(a_idle_holds, aclk, aresetn,
        step_en && phase_reg == PS_IDLE && !item.func, phase_reg == PS_IDLE)
    `ASSERT_IMPL(a_status_on_done, aclk, aresetn,
        step_en && result.status != ST_OK, result.done_res && !result.busy_res)
    `ASSERT_ALWAYS(a_phase_range, aclk, aresetn,
        phase_reg < PS_RD_END || phase_reg == PS_IDLE)
    `ASSERT_IMPL(a_poll_bound, aclk, aresetn,
        phase_reg == PS_POLL, poll_reg < timeout_limit || poll_reg == '0)

endmodule

### hw/rtl/sensor_bus_measure_controller_unit.sv
// Measurement master for a two-wire humidity/temperature sensor bus.
// Each input transfer on s_ is one bus timing phase: func 0 is a plain tick
// carrying the sampled data level, func 1 starts a measurement (temperature
// or humidity by mode) when the sequencer is idle and is a tick otherwise.
// Every input transfer yields exactly one result transfer on m_ with the
// clock level, data drive and enable for that phase, busy/done/status and
// the reading and checksum registers.
// The input register takes each input transfer; the phase sequencer then
// moves it into the result register, which drives m_valid.
// Throughput: one phase per cycle while the result is taken; the sequencer
// state is updated in the same cycle the phase moves into the result register.
// When m_ready is low the result register holds and one more phase waits in
// the input register, after which s_ready falls until the result is taken.
// cfg_wr_en writes the 20-bit poll timeout limit; a limit of
// zero acts as one. After reset the sequencer is idle, the limit is 400000,
// the reading and checksum are zero and both channels are empty.
module sensor_bus_measure_controller_unit #(
    parameter int RESET_CLOCKS = 9
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sbmc_pkg::sbmc_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sbmc_pkg::sbmc_out_t m_data,
    input  logic                cfg_wr_en,
    input  logic [19:0]         cfg_wr_data
);
    import sbmc_pkg::*;

    logic        in_valid_reg, in_valid_next;
    sbmc_in_t    in_data_reg;
    logic        out_valid_reg, out_valid_next;
    sbmc_out_t   out_data_reg;
    logic [19:0] limit_reg;
    logic        step_en;
    sbmc_out_t   step_res;

    // Handshake between input register, sequencer and result register.
    always_comb begin
        step_en        = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready        = !in_valid_reg || step_en;
        in_valid_next  = (s_valid && s_ready) ? 1'b1 : (step_en ? 1'b0 : in_valid_reg);
        out_valid_next = step_en ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    sbmc_seq #(
        .RESET_CLOCKS(RESET_CLOCKS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .item         (in_data_reg),
        .timeout_limit(limit_reg),
        .result       (step_res)
    );

    // Control registers and the timeout limit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= TIMEOUT_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step_en) begin
            out_data_reg <= step_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
